[design/qtpm_pkg.sv]
// ----------------------------------------------------------------------------
// Quadrant tile mapper package
// Shared widths, register indexes, state codes and the command and status
// structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package qtpm_pkg;

  localparam int CoordW    = 13;
  localparam int ChanW     = 3;
  localparam int IdxW      = 3;
  localparam int DataW     = 13;
  localparam int PktW      = 9;
  localparam int SrcW      = 26;
  localparam int LedW      = 8;
  localparam int PosW      = 4;
  localparam int MulBW     = 13;
  localparam int XyW       = 18;
  localparam int RcpW      = 17;
  localparam int ScaleSh   = 17;
  localparam int PktHeader = 21;

  typedef enum logic [IdxW-1:0] {
    REG_VIDEO_X         = 3'd0,
    REG_VIDEO_Y         = 3'd1,
    REG_VIDEO_W         = 3'd2,
    REG_VIDEO_H         = 3'd3,
    REG_SOURCE_WIDTH    = 3'd4,
    REG_SOURCE_HEIGHT   = 3'd5,
    REG_SOURCE_CHANNELS = 3'd6,
    REG_ROTATION        = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [1:0] {
    QUAD_UL = 2'd0,
    QUAD_LL = 2'd1,
    QUAD_LR = 2'd2,
    QUAD_UR = 2'd3
  } quad_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DLOAD,
    S_DSTORE,
    S_MX,
    S_MY,
    S_FORMY,
    S_MW,
    S_MC
  } state_t;

  typedef struct packed {
    logic cfg_we;
    logic accept;
    logic div_load;
    logic div_store;
    logic div_sel_y;
    logic mul_x;
    logic mul_y;
    logic form_y;
    logic mul_w;
    logic mul_c;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[design/qtpm_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Carries one scan request: restart the scan or advance to the next LED.
// ----------------------------------------------------------------------------
interface qtpm_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

[design/qtpm_rsp_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Carries the packet offset, source address and flags of one LED.
// ----------------------------------------------------------------------------
interface qtpm_rsp_if;
  import qtpm_pkg::*;
  logic            valid;
  logic            ready;
  logic [PktW-1:0] packet_offset;
  logic [SrcW-1:0] source_offset;
  logic            in_range;
  logic            last;

  modport source (output valid, output packet_offset, output source_offset,
                  output in_range, output last, input ready);
  modport sink (input valid, input packet_offset, input source_offset,
                input in_range, input last, output ready);
endinterface

[design/qtpm_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration channel
// Carries one register write: register index and write data.
// ----------------------------------------------------------------------------
interface qtpm_cfg_if;
  import qtpm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  idx;
  logic [DataW-1:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

[design/qtpm_ctrl.sv]
// ----------------------------------------------------------------------------
// Quadrant tile mapper controller
// Sequences register writes, the scale division and the multiply steps of
// each LED, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module qtpm_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [qtpm_pkg::IdxW-1:0] cfg_idx,
  input  qtpm_pkg::sts_t           sts,
  output qtpm_pkg::cmd_t           cmd
);
  import qtpm_pkg::*;

  state_t   state;
  state_t   state_next;
  logic     sel_y;
  logic     sel_y_next;
  reg_idx_t widx;

  assign widx = reg_idx_t'(cfg_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel_y <= 1'b0;
    end else begin
      state <= state_next;
      sel_y <= sel_y_next;
    end
  end

  always_comb begin
    state_next    = state;
    sel_y_next    = sel_y;
    cmd           = '0;
    cmd.div_sel_y = sel_y;
    req_ready     = 1'b0;
    cfg_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        cfg_ready = 1'b1;
        req_ready = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_we = 1'b1;
          if (widx == REG_VIDEO_W || widx == REG_VIDEO_H) begin
            sel_y_next = (widx == REG_VIDEO_H);
            state_next = S_DLOAD;
          end
        end else if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_MX;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DSTORE;
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        state_next    = S_IDLE;
      end
      S_MX: begin
        cmd.mul_x  = 1'b1;
        state_next = S_MY;
      end
      S_MY: begin
        cmd.mul_y  = 1'b1;
        state_next = S_FORMY;
      end
      S_FORMY: begin
        cmd.form_y = 1'b1;
        state_next = S_MW;
      end
      S_MW: begin
        cmd.mul_w  = 1'b1;
        state_next = S_MC;
      end
      S_MC: begin
        cmd.mul_c = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/qtpm_datapath.sv]
// ----------------------------------------------------------------------------
// Quadrant tile mapper datapath
// Holds the registers, the scan position, the reciprocal scale divider, the
// shared multiplier and the result register.
// ----------------------------------------------------------------------------
module qtpm_datapath #(
  parameter int TILE_W = 12,
  parameter int TILE_H = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [qtpm_pkg::IdxW-1:0]  cfg_idx,
  input  logic [qtpm_pkg::DataW-1:0] cfg_data,
  input  logic                      out_ready,
  input  qtpm_pkg::cmd_t            cmd,
  output qtpm_pkg::sts_t            sts,
  output logic                      out_valid,
  output logic [qtpm_pkg::PktW-1:0]  packet_offset,
  output logic [qtpm_pkg::SrcW-1:0]  source_offset,
  output logic                      in_range,
  output logic                      last
);
  import qtpm_pkg::*;

  localparam int HalfW   = TILE_W / 2;
  localparam int HalfH   = TILE_H / 2;
  localparam int XScaleR = 12 / TILE_W;
  localparam int YScaleR = 12 / TILE_H;

  localparam logic [RcpW-1:0] XRecip = RcpW'((2 ** ScaleSh + TILE_W - 1) / TILE_W);
  localparam logic [RcpW-1:0] YRecip = RcpW'((2 ** ScaleSh + TILE_H - 1) / TILE_H);

  localparam logic [PosW-1:0] ColStart = PosW'(HalfW - 1);
  localparam logic [PosW-1:0] ColRight = PosW'(TILE_W - 1);
  localparam logic [PosW-1:0] ColSplit = PosW'(HalfW);
  localparam logic [PosW-1:0] RowHalf  = PosW'(HalfH);
  localparam logic [PosW-1:0] RowLow   = PosW'(TILE_H - HalfH);
  localparam logic [PosW-1:0] RowLastU = PosW'(HalfH - 1);
  localparam logic [PosW-1:0] RowLastL = PosW'(TILE_H - 1);
  localparam logic [PosW-1:0] WMax     = PosW'(TILE_W - 1);
  localparam logic [PosW-1:0] HMax     = PosW'(TILE_H - 1);

  logic [CoordW-1:0] video_x;
  logic [CoordW-1:0] video_y;
  logic [CoordW-1:0] video_w;
  logic [CoordW-1:0] video_h;
  logic [CoordW-1:0] source_width;
  logic [CoordW-1:0] source_height;
  logic [ChanW-1:0]  source_channels;
  rot_t              rotation;
  logic [CoordW-1:0] x_scale;
  logic [CoordW-1:0] y_scale;

  quad_t             quadrant;
  logic [PosW-1:0]   column;
  logic [PosW-1:0]   row;
  logic [LedW-1:0]   led_count;

  quad_t             p_q;
  logic [PosW-1:0]   p_c;
  logic [PosW-1:0]   p_r;
  logic [LedW-1:0]   p_n;
  quad_t             n_q;
  logic [PosW-1:0]   n_c;
  logic [PosW-1:0]   n_r;
  logic              wrap;
  logic              lower;
  logic [PosW-1:0]   row_last;
  logic [PosW-1:0]   col_end;

  logic [PosW-1:0]   cur_c;
  logic [PosW-1:0]   cur_r;
  logic [LedW-1:0]   cur_n;
  logic              cur_last;

  logic [PosW-1:0]   fx;
  logic [PosW-1:0]   fy;
  logic              fx_y;
  logic              fy_y;

  logic [SrcW-1:0]       mul_a;
  logic [MulBW-1:0]      mul_b;
  logic [SrcW+MulBW-1:0] mul_full;
  logic [SrcW-1:0]       mul_p;
  logic [SrcW-1:0]       prod;
  logic [XyW-1:0]        xx;
  logic [XyW-1:0]        yy;
  logic [XyW-1:0]        yy_c;
  logic                  ok;
  logic                  ok_c;

  logic [CoordW-1:0]      div_in;
  logic [RcpW-1:0]        recip;
  logic [CoordW+RcpW-1:0] scale_full;
  logic [CoordW-1:0]      scale_q;

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      video_x         <= '0;
      video_y         <= '0;
      video_w         <= CoordW'(12);
      video_h         <= CoordW'(12);
      source_width    <= CoordW'(1);
      source_height   <= CoordW'(1);
      source_channels <= ChanW'(3);
      rotation        <= ROT_0;
    end else if (cmd.cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_VIDEO_X:         video_x         <= cfg_data;
        REG_VIDEO_Y:         video_y         <= cfg_data;
        REG_VIDEO_W:         video_w         <= cfg_data;
        REG_VIDEO_H:         video_h         <= cfg_data;
        REG_SOURCE_WIDTH:    source_width    <= cfg_data;
        REG_SOURCE_HEIGHT:   source_height   <= cfg_data;
        REG_SOURCE_CHANNELS: source_channels <= cfg_data[ChanW-1:0];
        REG_ROTATION:        rotation        <= rot_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Scale divider: multiplication by the rounded-up reciprocal of the tile
  // size, exact for every 13-bit video size.
  assign div_in     = cmd.div_sel_y ? video_h : video_w;
  assign recip      = cmd.div_sel_y ? YRecip : XRecip;
  assign scale_full = div_in * recip;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      scale_q <= scale_full[ScaleSh +: CoordW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale <= CoordW'(XScaleR);
      y_scale <= CoordW'(YScaleR);
    end else if (cmd.div_store) begin
      if (cmd.div_sel_y) begin
        y_scale <= scale_q;
      end else begin
        x_scale <= scale_q;
      end
    end
  end

  // Scan position and its successor in wiring order.
  always_comb begin
    if (restart) begin
      p_q = QUAD_UL;
      p_c = ColStart;
      p_r = '0;
      p_n = '0;
    end else begin
      p_q = quadrant;
      p_c = column;
      p_r = row;
      p_n = led_count;
    end
    lower    = (p_q == QUAD_LL) || (p_q == QUAD_LR);
    row_last = lower ? RowLastL : RowLastU;
    col_end  = (p_q == QUAD_LR || p_q == QUAD_UR) ? ColSplit : '0;
    n_q      = p_q;
    n_c      = p_c;
    n_r      = p_r + PosW'(1);
    wrap     = 1'b0;
    if (p_r == row_last) begin
      n_r = lower ? RowLow : '0;
      n_c = p_c - PosW'(1);
      if (p_c == col_end) begin
        unique case (p_q)
          QUAD_UL: begin
            n_q = QUAD_LL;
            n_c = ColStart;
            n_r = RowHalf;
          end
          QUAD_LL: begin
            n_q = QUAD_LR;
            n_c = ColRight;
            n_r = RowHalf;
          end
          QUAD_LR: begin
            n_q = QUAD_UR;
            n_c = ColRight;
            n_r = '0;
          end
          QUAD_UR: begin
            n_q  = QUAD_UL;
            n_c  = ColStart;
            n_r  = '0;
            wrap = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quadrant  <= QUAD_UL;
      column    <= ColStart;
      row       <= '0;
      led_count <= '0;
    end else if (cmd.accept) begin
      quadrant  <= n_q;
      column    <= n_c;
      row       <= n_r;
      led_count <= wrap ? '0 : p_n + LedW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_c    <= p_c;
      cur_r    <= p_r;
      cur_n    <= p_n;
      cur_last <= wrap;
    end
  end

  // Per-axis factors after rotation.
  always_comb begin
    unique case (rotation)
      ROT_0: begin
        fx = cur_c;           fx_y = 1'b0;
        fy = HMax - cur_r;    fy_y = 1'b1;
      end
      ROT_90: begin
        fx = HMax - cur_r;    fx_y = 1'b1;
        fy = cur_c;           fy_y = 1'b0;
      end
      ROT_180: begin
        fx = WMax - cur_c;    fx_y = 1'b0;
        fy = cur_r;           fy_y = 1'b1;
      end
      ROT_270: begin
        fx = cur_r;           fx_y = 1'b1;
        fy = WMax - cur_c;    fy_y = 1'b0;
      end
      default: begin
        fx = cur_c;           fx_y = 1'b0;
        fy = HMax - cur_r;    fy_y = 1'b1;
      end
    endcase
  end

  // Shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_x) begin
      mul_a = SrcW'(fx);
      mul_b = fx_y ? y_scale : x_scale;
    end else if (cmd.mul_y) begin
      mul_a = SrcW'(fy);
      mul_b = fy_y ? y_scale : x_scale;
    end else if (cmd.mul_w) begin
      mul_a = SrcW'(yy[CoordW-1:0]);
      mul_b = source_width;
    end else if (cmd.mul_c) begin
      mul_a = SrcW'(xx[CoordW-1:0]) + prod;
      mul_b = MulBW'(source_channels);
    end
  end

  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[SrcW-1:0];

  assign yy_c = {{(XyW-CoordW){video_y[CoordW-1]}}, video_y} + XyW'(prod[XyW-2:0]);
  assign ok_c = !xx[XyW-1] && (xx[XyW-2:0] < (XyW-1)'(source_width)) &&
                !yy_c[XyW-1] && (yy_c[XyW-2:0] < (XyW-1)'(source_height));

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y || cmd.mul_w) begin
      prod <= mul_p;
    end
    if (cmd.mul_y) begin
      xx <= {{(XyW-CoordW){video_x[CoordW-1]}}, video_x} + XyW'(prod[XyW-2:0]);
    end
    if (cmd.form_y) begin
      yy <= yy_c;
      ok <= ok_c;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      packet_offset <= PktW'(PktHeader) + PktW'({cur_n, 1'b0}) + PktW'(cur_n);
      source_offset <= ok ? mul_p : '0;
      in_range      <= ok;
      last          <= cur_last;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

[design/quadrant_tile_pixel_mapper_rotated.sv]
// ----------------------------------------------------------------------------
// Quadrant tile pixel mapper, rotatable
// Walks the LEDs of a four-quadrant tile and gives each LED's packet offset
// and the byte address of its sampled source pixel.
// ----------------------------------------------------------------------------
// A request's result is registered after its multiply steps, once the result
// register is free; no new request is taken until then. The shared multiplier
// is used four times per LED (two scale products, row stride, pixel size).
// A write to video_w or video_h keeps the block busy while the scale is
// formed by multiplying with the reciprocal of the tile size.
// Reset: synchronous; registers take their reset values and the scan restarts.
module quadrant_tile_pixel_mapper_rotated #(
  parameter int TILE_W = 12,
  parameter int TILE_H = 12
) (
  input logic        clk,
  input logic        rst,
  qtpm_req_if.sink   req,
  qtpm_rsp_if.source rsp,
  qtpm_cfg_if.sink   cfg
);
  import qtpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  qtpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_idx   (cfg.idx),
    .sts       (sts),
    .cmd       (cmd)
  );

  qtpm_datapath #(
    .TILE_W (TILE_W),
    .TILE_H (TILE_H)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .restart       (req.restart),
    .cfg_idx       (cfg.idx),
    .cfg_data      (cfg.data),
    .out_ready     (rsp.ready),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (rsp.valid),
    .packet_offset (rsp.packet_offset),
    .source_offset (rsp.source_offset),
    .in_range      (rsp.in_range),
    .last          (rsp.last)
  );

endmodule

[design/qtpm_checker.sv]
// ----------------------------------------------------------------------------
// Quadrant tile mapper port checker
// Checks the result channel and request sequencing as seen at the ports.
// ----------------------------------------------------------------------------
module qtpm_checker #(
  parameter int TILE_W = 12,
  parameter int TILE_H = 12
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [qtpm_pkg::PktW-1:0] packet_offset,
  input logic [qtpm_pkg::SrcW-1:0] source_offset,
  input logic                      in_range,
  input logic                      last
);
  import qtpm_pkg::*;

  localparam int PktMax = PktHeader + 3 * (TILE_W * TILE_H - 1);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(packet_offset) &&
      $stable(source_offset) && $stable(in_range) && $stable(last))
    else $error("Result changed while stalled.");

  a_rsp_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("Result valid after reset.");

  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !in_range |-> source_offset == '0)
    else $error("Black LED carries a source address.");

  a_pkt_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> packet_offset >= PktW'(PktHeader) && packet_offset <= PktW'(PktMax))
    else $error("Packet offset outside the tile.");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Request taken while one is still at work.");

endmodule

bind quadrant_tile_pixel_mapper_rotated qtpm_checker #(
  .TILE_W (TILE_W),
  .TILE_H (TILE_H)
) u_qtpm_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .packet_offset (rsp.packet_offset),
  .source_offset (rsp.source_offset),
  .in_range      (rsp.in_range),
  .last          (rsp.last)
);

[tb/quadrant_tile_pixel_mapper_rotated_tb.sv]
// ----------------------------------------------------------------------------
// Quadrant tile pixel mapper testbench
// Sends scan requests and register writes to the mapper and checks every LED
// result, field by field, against the typed table values or a predictor of
// the tile walk and sampling. A short table of requests runs first. Phases
// follow, each with fresh register settings and random requests, with random
// gaps on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module quadrant_tile_pixel_mapper_rotated_tb;
  import qtpm_pkg::*;

  localparam int TileW        = 12;
  localparam int TileH        = 12;
  localparam int NumDirected  = 20;
  localparam int NumPhases    = 10;
  localparam int HoldPhase    = 5;
  localparam int MaxIdle      = 16;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 12;

  typedef struct packed {
    logic [PktW-1:0] packet_offset;
    logic [SrcW-1:0] source_offset;
    logic            in_range;
    logic            last;
  } led_t;

  typedef struct packed {
    logic            restart;
    logic            typed;
    logic [PktW-1:0] pkt;
    logic [SrcW-1:0] src;
    logic            in_range;
    logic            last;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;

  qtpm_req_if req_ch ();
  qtpm_rsp_if rsp_ch ();
  qtpm_cfg_if cfg_ch ();

  quadrant_tile_pixel_mapper_rotated #(
    .TILE_W(TileW),
    .TILE_H(TileH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  logic signed [CoordW-1:0] vid_x, vid_y;
  logic [CoordW-1:0]        vid_w, vid_h, src_w, src_h;
  logic [ChanW-1:0]         chans;
  rot_t                     rot;
  int                       x_scale, y_scale;
  quad_t                    quad;
  int                       col, row;
  logic [LedW-1:0]          led_idx;

  led_t             expected_leds [$];
  int               error_count = 0;
  bit               idle_on = 1'b1;
  bit               hold_req = 1'b0;
  logic [DataW-1:0] reg_plan [8];

  dir_row_t dir_rows [NumDirected] = '{
    '{1'b0, 1'b1, 9'd21, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 9'd24, 26'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 9'd21, 26'd0, 1'b0, 1'b0},
    '{1'b1, 1'b1, 9'd21, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0},
    '{1'b0, 1'b0, 9'd0, 26'd0, 1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("quadrant_tile_pixel_mapper_rotated_tb: done, errors");
    $finish;
  end

  function automatic void restart_scan();
    quad    = QUAD_UL;
    col     = TileW / 2 - 1;
    row     = 0;
    led_idx = '0;
  endfunction

  function automatic void apply_reg(reg_idx_t idx, logic [DataW-1:0] data);
    case (idx)
      REG_VIDEO_X:         vid_x = data;
      REG_VIDEO_Y:         vid_y = data;
      REG_VIDEO_W:         vid_w = data;
      REG_VIDEO_H:         vid_h = data;
      REG_SOURCE_WIDTH:    src_w = data;
      REG_SOURCE_HEIGHT:   src_h = data;
      REG_SOURCE_CHANNELS: chans = data[ChanW-1:0];
      default:             rot   = rot_t'(data[1:0]);
    endcase
    x_scale = int'(vid_w) / TileW;
    y_scale = int'(vid_h) / TileH;
  endfunction

  // Works out the LED at the current scan position, then steps the scan on.
  function automatic led_t map_led(logic restart);
    longint vx, vy, c, r, xx, yy, addr;
    int     top, right;
    led_t   res;
    if (restart) begin
      restart_scan();
    end
    vx = longint'(vid_x);
    vy = longint'(vid_y);
    c  = col;
    r  = row;
    case (rot)
      ROT_90: begin
        xx = vx + (TileH - r - 1) * y_scale;
        yy = vy + c * x_scale;
      end
      ROT_180: begin
        xx = vx + (TileW - c - 1) * x_scale;
        yy = vy + r * y_scale;
      end
      ROT_270: begin
        xx = vx + r * y_scale;
        yy = vy + (TileW - c - 1) * x_scale;
      end
      default: begin
        xx = vx + c * x_scale;
        yy = vy + (TileH - r - 1) * y_scale;
      end
    endcase
    res.in_range = xx >= 0 && xx < longint'(src_w) && yy >= 0 && yy < longint'(src_h);
    addr = res.in_range ? (xx + yy * longint'(src_w)) * longint'(chans) : 0;
    res.source_offset = addr[SrcW-1:0];
    res.packet_offset = PktW'(PktHeader + 3 * int'(led_idx));
    res.last = 1'b0;

    led_idx++;
    top   = (quad == QUAD_LL || quad == QUAD_LR) ? TileH : TileH / 2;
    right = (quad == QUAD_LR || quad == QUAD_UR) ? TileW / 2 - 1 : -1;
    c = col;
    r = row + 1;
    if (r >= top) begin
      c--;
      r = top - TileH / 2;
      if (c <= right) begin
        case (quad)
          QUAD_UL: begin
            quad = QUAD_LL;
            c = TileW / 2 - 1;
            r = TileH / 2;
          end
          QUAD_LL: begin
            quad = QUAD_LR;
            c = TileW - 1;
            r = TileH / 2;
          end
          QUAD_LR: begin
            quad = QUAD_UR;
            c = TileW - 1;
            r = 0;
          end
          default: begin
            quad = QUAD_UL;
            c = TileW / 2 - 1;
            r = 0;
            led_idx = '0;
            res.last = 1'b1;
          end
        endcase
      end
    end
    col = int'(c);
    row = int'(r);
    return res;
  endfunction

  task automatic send_req(input logic restart, input logic typed, input led_t typed_led);
    int   gap;
    led_t predicted;
    gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.restart <= restart;
    do @(posedge clk); while (!req_ch.ready);
    predicted = map_led(restart);
    expected_leds.insert(expected_leds.size(), typed ? typed_led : predicted);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_setting();
    reg_idx_t ri;
    ri = ri.first();
    do begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.idx   <= ri;
      cfg_ch.data  <= reg_plan[ri];
      do @(posedge clk); while (!cfg_ch.ready);
      apply_reg(ri, reg_plan[ri]);
      ri = ri.next();
    end while (ri != ri.first());
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic choose_setting(int phase);
    int sw, sh;
    case (phase)
      0: begin
        // Largest scales and strides: the source address wraps.
        reg_plan[REG_VIDEO_X]         = 13'd0;
        reg_plan[REG_VIDEO_Y]         = 13'd0;
        reg_plan[REG_VIDEO_W]         = 13'h1FFF;
        reg_plan[REG_VIDEO_H]         = 13'h1FFF;
        reg_plan[REG_SOURCE_WIDTH]    = 13'h1FFF;
        reg_plan[REG_SOURCE_HEIGHT]   = 13'h1FFF;
        reg_plan[REG_SOURCE_CHANNELS] = 13'd7;
        reg_plan[REG_ROTATION]        = ROT_0;
      end
      1: begin
        reg_plan[REG_VIDEO_X]         = 13'h1000;
        reg_plan[REG_VIDEO_Y]         = 13'h1000;
        reg_plan[REG_VIDEO_W]         = 13'd4096;
        reg_plan[REG_VIDEO_H]         = 13'd4096;
        reg_plan[REG_SOURCE_WIDTH]    = 13'd4096;
        reg_plan[REG_SOURCE_HEIGHT]   = 13'd4096;
        reg_plan[REG_SOURCE_CHANNELS] = 13'd4;
        reg_plan[REG_ROTATION]        = ROT_90;
      end
      2: begin
        reg_plan[REG_VIDEO_X]         = 13'd4095;
        reg_plan[REG_VIDEO_Y]         = 13'd4095;
        reg_plan[REG_VIDEO_W]         = 13'd0;
        reg_plan[REG_VIDEO_H]         = 13'd0;
        reg_plan[REG_SOURCE_WIDTH]    = 13'd4096;
        reg_plan[REG_SOURCE_HEIGHT]   = 13'd4096;
        reg_plan[REG_SOURCE_CHANNELS] = 13'd1;
        reg_plan[REG_ROTATION]        = ROT_180;
      end
      3: begin
        // An empty source leaves every LED black.
        reg_plan[REG_VIDEO_X]         = 13'd0;
        reg_plan[REG_VIDEO_Y]         = 13'd0;
        reg_plan[REG_VIDEO_W]         = 13'd12;
        reg_plan[REG_VIDEO_H]         = 13'd12;
        reg_plan[REG_SOURCE_WIDTH]    = 13'd0;
        reg_plan[REG_SOURCE_HEIGHT]   = 13'd0;
        reg_plan[REG_SOURCE_CHANNELS] = 13'd3;
        reg_plan[REG_ROTATION]        = ROT_270;
      end
      4: begin
        reg_plan[REG_VIDEO_X]         = 13'd0;
        reg_plan[REG_VIDEO_Y]         = 13'd0;
        reg_plan[REG_VIDEO_W]         = 13'd24;
        reg_plan[REG_VIDEO_H]         = 13'd24;
        reg_plan[REG_SOURCE_WIDTH]    = 13'd30;
        reg_plan[REG_SOURCE_HEIGHT]   = 13'd30;
        reg_plan[REG_SOURCE_CHANNELS] = 13'd0;
        reg_plan[REG_ROTATION]        = ROT_0;
      end
      default: begin
        if ($urandom_range(0, 9) < 7) begin
          sw = $urandom_range(1, 160);
          sh = $urandom_range(1, 160);
          reg_plan[REG_VIDEO_X]         = 13'($urandom_range(0, 40)) - 13'd20;
          reg_plan[REG_VIDEO_Y]         = 13'($urandom_range(0, 40)) - 13'd20;
          reg_plan[REG_VIDEO_W]         = 13'($urandom_range(0, sw + 24));
          reg_plan[REG_VIDEO_H]         = 13'($urandom_range(0, sh + 24));
          reg_plan[REG_SOURCE_WIDTH]    = 13'(sw);
          reg_plan[REG_SOURCE_HEIGHT]   = 13'(sh);
          reg_plan[REG_SOURCE_CHANNELS] = 13'($urandom_range(1, 4));
        end else begin
          reg_plan[REG_VIDEO_X]         = 13'($urandom);
          reg_plan[REG_VIDEO_Y]         = 13'($urandom);
          reg_plan[REG_VIDEO_W]         = 13'($urandom);
          reg_plan[REG_VIDEO_H]         = 13'($urandom);
          reg_plan[REG_SOURCE_WIDTH]    = 13'($urandom);
          reg_plan[REG_SOURCE_HEIGHT]   = 13'($urandom);
          reg_plan[REG_SOURCE_CHANNELS] = 13'($urandom);
        end
        reg_plan[REG_ROTATION] = 13'($urandom_range(0, 3));
      end
    endcase
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  initial begin
    int       stall;
    led_t     want;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, MaxIdle) : 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (expected_leds.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual packet_offset %0d",
                 $time, rsp_ch.packet_offset);
      end else begin
        want = expected_leds.pop_front();
        check_field("packet_offset", want.packet_offset, rsp_ch.packet_offset);
        check_field("source_offset", want.source_offset, rsp_ch.source_offset);
        check_field("in_range", want.in_range, rsp_ch.in_range);
        check_field("last", want.last, rsp_ch.last);
      end
    end
  end

  initial begin
    dir_row_t row_d;
    led_t     typed_led;
    int       n_items;
    int       restart_odds;
    logic     restart;
    req_ch.valid   <= 1'b0;
    req_ch.restart <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.idx     <= REG_VIDEO_X;
    cfg_ch.data    <= '0;
    vid_x = '0;
    vid_y = '0;
    vid_w = 13'd12;
    vid_h = 13'd12;
    src_w = 13'd1;
    src_h = 13'd1;
    chans = 3'd3;
    rot   = ROT_0;
    apply_reg(REG_ROTATION, ROT_0);
    restart_scan();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row_d = dir_rows[i];
      typed_led.packet_offset = row_d.pkt;
      typed_led.source_offset = row_d.src;
      typed_led.in_range      = row_d.in_range;
      typed_led.last          = row_d.last;
      send_req(row_d.restart, row_d.typed, typed_led);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      choose_setting(p);
      load_setting();
      idle_on = ($urandom_range(0, 3) != 0);
      if (p == HoldPhase) begin
        idle_on  = 1'b0;
        hold_req = 1'b1;
      end
      case (p % 4)
        0:       restart_odds = 0;
        2:       restart_odds = 3;
        default: restart_odds = 40;
      endcase
      n_items = (restart_odds == 0) ? 150 : 35;
      for (int i = 0; i < n_items; i++) begin
        restart = (restart_odds != 0) && ($urandom_range(1, restart_odds) == 1);
        send_req(restart, 1'b0, '0);
      end
    end
    drain();

    if (error_count == 0) begin
      $display("quadrant_tile_pixel_mapper_rotated_tb: done, clean");
    end else begin
      $display("quadrant_tile_pixel_mapper_rotated_tb: done, errors");
    end
    $finish;
  end

endmodule
